// ===== rtl/csv_field_splitter_unit_macros.svh =====
// Assertion macros for the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_UNIT_MACROS_SVH
`define CSV_FIELD_SPLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CSVS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("csv splitter assertion failed");

`define CSVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("csv splitter assertion failed");

`else

`define CSVS_ASSERT(label, clk, rstn, prop)

`define CSVS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/csvs_pkg.sv =====
// Types and constants shared by the CSV field splitter.
package csvs_pkg;

    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] BYTE_COMMA = 8'h2C;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] MARK0      = 8'hEF;
    localparam logic [7:0] MARK1      = 8'hBB;
    localparam logic [7:0] MARK2      = 8'hBF;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_FIELD   = 2'd1;
    localparam logic [1:0] KIND_LINE    = 2'd2;

    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_HELD1 = 2'd1;
    localparam logic [1:0] PHASE_HELD2 = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       inside_quotes;
        logic       quote_pending;
        logic       first_field;
        logic [1:0] mark_phase;
    } state_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0][1:0] kinds;
        logic [1:0]                  count;
    } bundle_t;

    localparam state_t STATE_RESET = '{
        inside_quotes: 1'b0,
        quote_pending: 1'b0,
        first_field:   1'b1,
        mark_phase:    PHASE_IDLE
    };

endpackage

// ===== rtl/csvs_decode.sv =====
// Per-byte tokenizer step: next state and the results one transaction causes.
module csvs_decode (
    input  csvs_pkg::state_t   st,
    input  csvs_pkg::in_item_t item,
    output csvs_pkg::state_t   st_next,
    output csvs_pkg::bundle_t  bundle
);
    import csvs_pkg::*;

    logic       flush;
    logic       emit;
    logic [7:0] emit_byte;
    logic [1:0] emit_kind;
    logic       cont;
    logic       unq;
    logic [7:0] b;

    assign b = item.data_byte;

    always_comb begin
        flush     = 1'b0;
        emit      = 1'b0;
        emit_byte = 8'd0;
        emit_kind = KIND_CONTENT;
        cont      = 1'b0;
        unq       = 1'b0;
        st_next   = st;

        if (item.action) begin
            flush     = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_LINE;
        end else if (st.quote_pending) begin
            st_next.quote_pending = 1'b0;
            if (b == BYTE_QUOTE) begin
                cont = 1'b1;
            end else begin
                st_next.inside_quotes = 1'b0;
                unq = 1'b1;
            end
        end else if (st.inside_quotes) begin
            if (b == BYTE_QUOTE) begin
                st_next.quote_pending = 1'b1;
            end else begin
                cont = 1'b1;
            end
        end else begin
            unq = 1'b1;
        end

        if (unq) begin
            priority if (b == BYTE_COMMA) begin
                flush     = 1'b1;
                emit      = 1'b1;
                emit_kind = KIND_FIELD;
                st_next.first_field = 1'b0;
            end else if (b == BYTE_QUOTE) begin
                st_next.inside_quotes = 1'b1;
            end else if (b == BYTE_CR) begin
                emit = 1'b0;
            end else begin
                cont = 1'b1;
            end
        end

        if (cont) begin
            emit_byte = b;
            if (!st.first_field) begin
                emit = 1'b1;
            end else begin
                unique case (st.mark_phase)
                    PHASE_IDLE: begin
                        if (b == MARK0) begin
                            st_next.mark_phase = PHASE_HELD1;
                        end else begin
                            st_next.mark_phase = PHASE_DONE;
                            emit = 1'b1;
                        end
                    end
                    PHASE_HELD1: begin
                        if (b == MARK1) begin
                            st_next.mark_phase = PHASE_HELD2;
                        end else begin
                            flush = 1'b1;
                            emit  = 1'b1;
                        end
                    end
                    PHASE_HELD2: begin
                        if (b == MARK2) begin
                            st_next.mark_phase = PHASE_DONE;
                        end else begin
                            flush = 1'b1;
                            emit  = 1'b1;
                        end
                    end
                    PHASE_DONE: begin
                        emit = 1'b1;
                    end
                endcase
            end
        end

        if (flush && st.first_field) begin
            st_next.mark_phase = PHASE_DONE;
        end

        if (item.action) begin
            st_next = STATE_RESET;
        end
    end

    always_comb begin : assemble_proc
        logic [1:0] n;
        n      = 2'd0;
        bundle = '0;
        if (flush && st.first_field) begin
            if (st.mark_phase == PHASE_HELD1 || st.mark_phase == PHASE_HELD2) begin
                bundle.bytes[n] = MARK0;
                bundle.kinds[n] = KIND_CONTENT;
                n = n + 2'd1;
            end
            if (st.mark_phase == PHASE_HELD2) begin
                bundle.bytes[n] = MARK1;
                bundle.kinds[n] = KIND_CONTENT;
                n = n + 2'd1;
            end
        end
        if (emit) begin
            bundle.bytes[n] = emit_byte;
            bundle.kinds[n] = emit_kind;
            n = n + 2'd1;
        end
        bundle.count = n;
    end

endmodule

// ===== rtl/csv_field_splitter_unit.sv =====
// CSV line tokenizer top level: state, result register and output drain.
//
//  channel | direction | payload                        | handshake
//  s_      | in        | action, data_byte              | s_valid / s_ready
//  m_      | out       | out_byte, out_kind, last_of_run | m_valid / m_ready
//
// One input transaction per cycle while s_ready is high; the results it
// causes (zero to three) sit in a result register and leave one per cycle.
// A new transaction is taken in the cycle the last result of the previous
// one leaves. Reset clears the tokenizer state and empties the result
// register. Stalls on m_ready hold the current result.
`include "csv_field_splitter_unit_macros.svh"

module csv_field_splitter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csvs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output csvs_pkg::out_item_t m_data
);
    import csvs_pkg::*;

    state_t     st_reg;
    state_t     st_next;
    bundle_t    bundle_new;
    bundle_t    bun_reg;
    logic [1:0] idx_reg;
    logic       m_last;
    logic       s_fire;
    logic       m_fire;

    csvs_decode u_decode (
        .st      (st_reg),
        .item    (s_data),
        .st_next (st_next),
        .bundle  (bundle_new)
    );

    assign m_valid = (bun_reg.count != 2'd0);
    assign m_last  = (idx_reg == bun_reg.count - 2'd1);
    assign s_ready = !m_valid || (m_ready && m_last);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign m_data.out_byte    = bun_reg.bytes[idx_reg];
    assign m_data.out_kind    = bun_reg.kinds[idx_reg];
    assign m_data.last_of_run = m_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= STATE_RESET;
            bun_reg.count <= 2'd0;
            idx_reg       <= 2'd0;
        end else begin
            if (s_fire) begin
                st_reg  <= st_next;
                bun_reg <= bundle_new;
                idx_reg <= 2'd0;
            end else if (m_fire) begin
                if (m_last) begin
                    bun_reg.count <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    `CSVS_ASSERT(a_idx_in_range, aclk, aresetn, m_valid |-> (idx_reg < bun_reg.count))
    `CSVS_ASSERT(a_marker_zero, aclk, aresetn, (m_valid && m_data.out_kind != KIND_CONTENT) |-> (m_data.out_byte == 8'd0))
    `CSVS_ASSERT(a_pending_quoted, aclk, aresetn, st_reg.quote_pending |-> st_reg.inside_quotes)
    `CSVS_ASSERT_NEXT(a_drain_empty, aclk, aresetn, m_fire && m_data.last_of_run && !s_fire, !m_valid)

endmodule

// ===== sim/tb.sv =====
// Testbench for the CSV field splitter: random and directed lines checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import csvs_pkg::*;

    localparam int ITEM_COUNT   = 170;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        in_item_t item;
        bit       drain;
    } pending_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    pending_t  pending_items[$];
    out_item_t expected_tokens[$];
    out_item_t step_tokens[$];

    logic       in_quotes;
    logic       quote_waiting;
    logic       at_first_field;
    logic [1:0] bom_phase;

    int  fail_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    bit  drain_next = 0;

    csv_field_splitter_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void reset_tokenizer();
        in_quotes      = 1'b0;
        quote_waiting  = 1'b0;
        at_first_field = 1'b1;
        bom_phase      = PHASE_IDLE;
    endfunction

    function automatic void emit(logic [7:0] b, logic [1:0] k);
        out_item_t t;
        t.out_byte    = b;
        t.out_kind    = k;
        t.last_of_run = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void flush_bom();
        if (at_first_field) begin
            if (bom_phase == PHASE_HELD1 || bom_phase == PHASE_HELD2) begin
                emit(MARK0, KIND_CONTENT);
            end
            if (bom_phase == PHASE_HELD2) begin
                emit(MARK1, KIND_CONTENT);
            end
            bom_phase = PHASE_DONE;
        end
    endfunction

    function automatic void take_content(logic [7:0] b);
        if (!at_first_field || bom_phase == PHASE_DONE) begin
            emit(b, KIND_CONTENT);
        end else if (bom_phase == PHASE_IDLE) begin
            if (b == MARK0) begin
                bom_phase = PHASE_HELD1;
            end else begin
                bom_phase = PHASE_DONE;
                emit(b, KIND_CONTENT);
            end
        end else if (bom_phase == PHASE_HELD1) begin
            if (b == MARK1) begin
                bom_phase = PHASE_HELD2;
            end else begin
                flush_bom();
                emit(b, KIND_CONTENT);
            end
        end else begin
            if (b == MARK2) begin
                bom_phase = PHASE_DONE;
            end else begin
                flush_bom();
                emit(b, KIND_CONTENT);
            end
        end
    endfunction

    function automatic void take_unquoted(logic [7:0] b);
        if (b == BYTE_COMMA) begin
            flush_bom();
            emit(8'h00, KIND_FIELD);
            at_first_field = 1'b0;
        end else if (b == BYTE_QUOTE) begin
            in_quotes = 1'b1;
        end else if (b != BYTE_CR) begin
            take_content(b);
        end
    endfunction

    function automatic void predict_tokens(in_item_t it);
        step_tokens.delete();
        if (it.action) begin
            flush_bom();
            emit(8'h00, KIND_LINE);
            reset_tokenizer();
        end else if (quote_waiting) begin
            quote_waiting = 1'b0;
            if (it.data_byte == BYTE_QUOTE) begin
                take_content(it.data_byte);
            end else begin
                in_quotes = 1'b0;
                take_unquoted(it.data_byte);
            end
        end else if (in_quotes) begin
            if (it.data_byte == BYTE_QUOTE) begin
                quote_waiting = 1'b1;
            end else begin
                take_content(it.data_byte);
            end
        end else begin
            take_unquoted(it.data_byte);
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
        end
        foreach (step_tokens[i]) begin
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
        end
    endfunction

    function automatic void push_item(logic a, logic [7:0] b);
        pending_t p;
        p.item.action    = a;
        p.item.data_byte = b;
        p.drain          = drain_next;
        drain_next       = 0;
        pending_items.insert(pending_items.size(), p);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        push_item(1'b0, b);
    endfunction

    function automatic void push_eol();
        push_item(1'b1, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_COMMA || b == BYTE_QUOTE || b == BYTE_CR) begin
            b = 8'h61 + 8'($urandom_range(0, 25));
        end
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 6))
            0: return BYTE_QUOTE;
            1: return BYTE_COMMA;
            2: return BYTE_CR;
            3: return MARK0;
            4: return MARK1;
            5: return MARK2;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_random_line();
        int nf;
        int len;
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) == 0) begin
                push_byte(MARK0);
                push_byte(MARK1);
                push_byte(MARK2);
            end
            nf = $urandom_range(1, 4);
            for (int f = 0; f < nf; f++) begin
                if (f > 0) begin
                    push_byte(BYTE_COMMA);
                end
                len = $urandom_range(0, 4);
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(BYTE_QUOTE);
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(0, 4))
                            0: begin
                                push_byte(BYTE_QUOTE);
                                push_byte(BYTE_QUOTE);
                            end
                            1: push_byte(BYTE_COMMA);
                            2: push_byte(BYTE_CR);
                            default: push_byte(plain_byte());
                        endcase
                    end
                    push_byte(BYTE_QUOTE);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        push_byte(plain_byte());
                    end
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                push_byte(BYTE_CR);
            end
        end else begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                push_byte(noise_byte());
            end
        end
        push_eol();
    endfunction

    always @(posedge aclk) begin
        logic     next_valid;
        in_item_t next_data;
        pending_t p;
        next_valid = s_valid;
        next_data  = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_tokens.size() > 0)) begin
                    p = pending_items.pop_front();
                    next_valid = 1'b1;
                    next_data  = p.item;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    always @(posedge aclk) begin
        out_item_t want;
        logic      ready_next;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result: out_byte %0h out_kind %0d last_of_run %0b",
                       m_data.out_byte, m_data.out_kind, m_data.last_of_run);
                fail_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, m_data.out_byte);
                    fail_count++;
                end
                if (m_data.out_kind !== want.out_kind) begin
                    $error("out_kind: expected %0d, actual %0d", want.out_kind, m_data.out_kind);
                    fail_count++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, m_data.last_of_run);
                    fail_count++;
                end
            end
        end
        if (cycle_count % 50 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = (cycle_count % 7) >= 3;
        endcase
        m_ready <= ready_next;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int line_no;
        reset_tokenizer();

        push_eol();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(BYTE_COMMA);
        push_eol();
        push_byte(MARK0);
        push_byte(MARK1);
        push_byte(MARK2);
        push_text("A");
        push_eol();
        push_byte(MARK0);
        push_byte(BYTE_COMMA);
        push_eol();
        push_byte(MARK0);
        push_byte(MARK1);
        push_eol();
        push_byte(MARK0);
        push_byte(MARK1);
        push_text("C");
        push_eol();
        push_text("\"a\"\"");
        push_byte(BYTE_CR);
        push_text(",\"x");
        push_byte(BYTE_CR);
        push_eol();
        push_text("\"a\"");
        push_eol();
        push_text("\"b");
        push_eol();

        line_no = 0;
        while (pending_items.size() < ITEM_COUNT) begin
            if (line_no == 5 || line_no == 15) begin
                drain_next = 1;
            end
            push_random_line();
            line_no++;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_valid || expected_tokens.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
